// ===== sv/odp_pkg.sv =====
package odp_pkg;

  localparam int LEVEL_W  = 8;
  localparam int COUNT_W  = 7;
  localparam int PROD_W   = LEVEL_W + COUNT_W;
  localparam int CODE_W   = 3;
  localparam int ADDR_W   = 3 * CODE_W;
  localparam int PAL_W    = 9;
  localparam int TBL_DEPTH = 1 << ADDR_W;
  localparam int INDEX_BITS_DEFAULT = 9;

  localparam logic [0:0] CMD_PIXEL = 1'b0;
  localparam logic [0:0] CMD_WRITE = 1'b1;

  // 4x4 Bayer thresholds, indexed by {row, col}
  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  typedef struct packed {
    logic              we;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic [PAL_W-1:0]  wdata;
  } tbl_req_t;

  // Pick the top three bits of the scaled level, bumped by one when the low
  // nibble beats the threshold; hold at the top code.
  function automatic logic [CODE_W-1:0] dither_code(input logic [PROD_W-1:0] prod,
                                                    input logic [3:0] thr);
    logic [COUNT_W-1:0] scaled;
    logic [CODE_W-1:0]  hi;
    scaled = prod[PROD_W-1:LEVEL_W];
    hi     = scaled[COUNT_W-1:4];
    if (hi == {CODE_W{1'b1}} || scaled[3:0] <= thr) begin
      return hi;
    end
    return hi + CODE_W'(1);
  endfunction

endpackage

// ===== sv/odp_table.sv =====
module odp_table #(
  parameter int INDEX_BITS = odp_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  odp_pkg::tbl_req_t     req,
  output logic                  busy,
  output logic [INDEX_BITS-1:0] rd_data
);

  localparam int AW = odp_pkg::ADDR_W;

  logic [INDEX_BITS-1:0] mem [odp_pkg::TBL_DEPTH];
  logic [AW:0]           clr_cnt;

  assign busy = ~clr_cnt[AW];

  // sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt[AW-1:0]] <= '0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata[INDEX_BITS-1:0];
    end
    if (req.rd) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

// ===== sv/ordered_dither_palette_index.sv =====
// Ordered-dither palette lookup.
// Input channel (in_valid / in_stall) carries one word per cycle unless
// stalled. cmd selects a pixel (col_low, row_low, red_in, green_in, blue_in)
// or a table write (entry_addr, entry_value). A pixel yields one palette_index
// word on the output channel (out_valid / out_stall); a table write yields
// nothing. Each channel is scaled by intensity_count, dithered against a 4x4
// Bayer threshold and the three 3-bit codes address a 512-entry palette table.
// A pixel passes the scale stage, then the table read register. Throughput:
// one word per cycle unless stalled; the table's single read/write port takes
// one access per cycle, and table writes go in order with pixel reads. Reset
// clears the pipeline and the intensity register, then sweeps the table to
// zero with in_stall high; cfg writes are taken meanwhile. When out_stall
// holds, the output word and table read register hold; one more word may
// enter the scale stage before in_stall rises. The user must write
// intensity_count via cfg_wr_en / cfg_wr_data only while idle (not enforced).
module ordered_dither_palette_index #(
  parameter int INDEX_BITS = odp_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [odp_pkg::COUNT_W-1:0]         cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [1:0]                          col_low,
  input  logic [1:0]                          row_low,
  input  logic [odp_pkg::LEVEL_W-1:0]         red_in,
  input  logic [odp_pkg::LEVEL_W-1:0]         green_in,
  input  logic [odp_pkg::LEVEL_W-1:0]         blue_in,
  input  logic [odp_pkg::ADDR_W-1:0]          entry_addr,
  input  logic [odp_pkg::PAL_W-1:0]           entry_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [odp_pkg::PAL_W-1:0]           palette_index
);

  localparam int PW = odp_pkg::PAL_W;
  localparam int CW = odp_pkg::CODE_W;

  logic [odp_pkg::COUNT_W-1:0] intensity_count;

  logic                        p1_valid;
  logic                        p1_cmd;
  logic [odp_pkg::PROD_W-1:0]  p1_prod_r;
  logic [odp_pkg::PROD_W-1:0]  p1_prod_g;
  logic [odp_pkg::PROD_W-1:0]  p1_prod_b;
  logic [3:0]                  p1_thr;
  logic [odp_pkg::ADDR_W-1:0]  p1_addr;
  logic [PW-1:0]               p1_wdata;

  logic                        adv;
  logic                        p1_ready;
  logic                        accept;
  logic                        busy;
  logic [CW-1:0]               code_r;
  logic [CW-1:0]               code_g;
  logic [CW-1:0]               code_b;
  odp_pkg::tbl_req_t           req;
  logic [INDEX_BITS-1:0]       rd_data;

  assign adv      = ~out_valid | ~out_stall;
  assign p1_ready = ~p1_valid | adv;
  assign in_stall = busy | ~p1_ready;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_count <= '0;
    end else if (cfg_wr_en) begin
      intensity_count <= cfg_wr_data;
    end
  end

  // scale stage: one multiply per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (p1_ready) begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_cmd    <= cmd;
      p1_prod_r <= odp_pkg::PROD_W'(red_in)   * odp_pkg::PROD_W'(intensity_count);
      p1_prod_g <= odp_pkg::PROD_W'(green_in) * odp_pkg::PROD_W'(intensity_count);
      p1_prod_b <= odp_pkg::PROD_W'(blue_in)  * odp_pkg::PROD_W'(intensity_count);
      p1_thr    <= odp_pkg::BAYER[{row_low, col_low}];
      p1_addr   <= entry_addr;
      p1_wdata  <= entry_value;
    end
  end

  // dither stage: form the code and issue the table access
  always_comb begin
    code_r    = odp_pkg::dither_code(p1_prod_r, p1_thr);
    code_g    = odp_pkg::dither_code(p1_prod_g, p1_thr);
    code_b    = odp_pkg::dither_code(p1_prod_b, p1_thr);
    req.we    = p1_valid & adv & (p1_cmd == odp_pkg::CMD_WRITE);
    req.rd    = p1_valid & adv & (p1_cmd == odp_pkg::CMD_PIXEL);
    req.addr  = (p1_cmd == odp_pkg::CMD_WRITE) ? p1_addr : {code_b, code_g, code_r};
    req.wdata = p1_wdata;
  end

  odp_table #(
    .INDEX_BITS(INDEX_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .busy    (busy),
    .rd_data (rd_data)
  );

  // table read register doubles as the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= req.rd;
    end
  end

  assign palette_index = PW'(rd_data);

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    busy |-> !p1_valid && !out_valid)
    else $error("pipeline holds a word during table clear");

  a_pixel_out: assert property (@(posedge clk) disable iff (rst)
    p1_valid && adv && p1_cmd == odp_pkg::CMD_PIXEL |=> out_valid)
    else $error("pixel lost between dither stage and output");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    p1_valid && adv && p1_cmd == odp_pkg::CMD_WRITE |=> !out_valid)
    else $error("table write produced an output word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !req.rd && !req.we)
    else $error("table accessed while output word is stalled");

endmodule

// ===== tb/sv/tb_ordered_dither_palette_index.sv =====
`timescale 1ns / 1ps

module tb_ordered_dither_palette_index;
  import odp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEGMENT_WORDS = 95;

  // Bayer thresholds by {row, col}, kept apart from the package copy
  localparam logic [3:0] THRESHOLD [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [COUNT_W-1:0]  cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic                cmd;
  logic [1:0]          col_low;
  logic [1:0]          row_low;
  logic [LEVEL_W-1:0]  red_in;
  logic [LEVEL_W-1:0]  green_in;
  logic [LEVEL_W-1:0]  blue_in;
  logic [ADDR_W-1:0]   entry_addr;
  logic [PAL_W-1:0]    entry_value;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PAL_W-1:0]    palette_index;

  logic [PAL_W-1:0]    palette_shadow [TBL_DEPTH];
  logic [COUNT_W-1:0]  count_shadow;
  logic [PAL_W-1:0]    palette_due [$];
  int                  send_idle_pct;
  int                  stall_pct;
  int                  mismatches;

  ordered_dither_palette_index dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .col_low       (col_low),
    .row_low       (row_low),
    .red_in        (red_in),
    .green_in      (green_in),
    .blue_in       (blue_in),
    .entry_addr    (entry_addr),
    .entry_value   (entry_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .palette_index (palette_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** ordered_dither_palette_index: FAILED **");
    $finish;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  function automatic logic [CODE_W-1:0] level_code(input logic [LEVEL_W-1:0] level,
                                                   input logic [3:0] thr);
    logic [PROD_W-1:0] prod;
    logic [6:0]        scaled;
    logic [3:0]        code;
    prod   = PROD_W'(level) * PROD_W'(count_shadow);
    scaled = prod[PROD_W-1:LEVEL_W];
    code   = {1'b0, scaled[6:4]};
    if (scaled[3:0] > thr) begin
      code = code + 4'd1;
    end
    // clamp at the top code when the count runs past 113
    if (code > 4'd7) begin
      code = 4'd7;
    end
    return code[CODE_W-1:0];
  endfunction

  function automatic logic [PAL_W-1:0] predict_index(input logic [1:0] col,
                                                     input logic [1:0] row,
                                                     input logic [LEVEL_W-1:0] r,
                                                     input logic [LEVEL_W-1:0] g,
                                                     input logic [LEVEL_W-1:0] b);
    logic [3:0]        thr;
    logic [ADDR_W-1:0] code;
    thr  = THRESHOLD[{row, col}];
    code = {level_code(b, thr), level_code(g, thr), level_code(r, thr)};
    return palette_shadow[code];
  endfunction

  task automatic log_mismatch(input string what, input logic [PAL_W-1:0] want,
                              input logic [PAL_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t: expected %h, got %h", what, $time, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (palette_due.size() == 0) begin
        log_mismatch("unexpected word", 'x, palette_index);
      end else if (palette_index !== palette_due[0]) begin
        log_mismatch("palette_index", palette_due.pop_front(), palette_index);
      end else begin
        void'(palette_due.pop_front());
      end
    end
  end

  // Called and returns at a falling edge; valid stays high across back-to-back words.
  task automatic send_word(input logic c, input logic [1:0] col, input logic [1:0] row,
                           input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
                           input logic [LEVEL_W-1:0] b, input logic [ADDR_W-1:0] addr,
                           input logic [PAL_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    cmd         = c;
    col_low     = col;
    row_low     = row;
    red_in      = r;
    green_in    = g;
    blue_in     = b;
    entry_addr  = addr;
    entry_value = value;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == CMD_WRITE) begin
      palette_shadow[addr] = value;
    end else begin
      palette_due.push_back(predict_index(col, row, r, g, b));
    end
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic [1:0] col, input logic [1:0] row,
                            input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
                            input logic [LEVEL_W-1:0] b);
    send_word(CMD_PIXEL, col, row, r, g, b, ADDR_W'($urandom), PAL_W'($urandom));
  endtask

  task automatic send_entry(input logic [ADDR_W-1:0] addr, input logic [PAL_W-1:0] value);
    send_word(CMD_WRITE, 2'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), addr, value);
  endtask

  task automatic send_random_word(input int write_pct);
    logic c;
    c = ($urandom_range(99) < write_pct) ? CMD_WRITE : CMD_PIXEL;
    send_word(c, 2'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), ADDR_W'($urandom), PAL_W'($urandom));
  endtask

  // Drop valid, wait out every pending word, then let the pipe empty.
  task automatic drain_words();
    in_valid = 1'b0;
    while (palette_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_intensity(input logic [COUNT_W-1:0] count);
    drain_words();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = count;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    count_shadow = count;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // Count and table straight out of reset: everything lands on entry zero.
  task automatic test_reset_state();
    send_pixel(2'd3, 2'd3, 8'hFF, 8'hFF, 8'hFF);
    send_entry(9'h000, 9'h1FF);
    send_pixel(2'd0, 2'd0, 8'hFF, 8'h80, 8'h01);
  endtask

  task automatic test_saturation();
    set_intensity(7'd127);
    send_entry(9'h1FF, 9'h0A5);
    send_entry(9'h000, 9'h15A);
    send_pixel(2'd0, 2'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(2'd1, 2'd2, 8'h00, 8'h00, 8'h00);
    send_pixel(2'd0, 2'd3, 8'hFF, 8'h00, 8'h00);
    set_intensity(7'd113);
    send_pixel(2'd2, 2'd1, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // Mid-scale level gives low nibble 8: walk thresholds below, equal to and above it.
  task automatic test_thresholds();
    send_entry(9'h0DB, 9'h123);
    send_entry(9'h124, 9'h0C9);
    for (int col = 0; col < 4; col++) begin
      send_pixel(2'(col), 2'd0, 8'd128, 8'd128, 8'd128);
      send_pixel(2'(col), 2'd3, 8'd128, 8'd128, 8'd128);
    end
  endtask

  task automatic test_table_fill();
    for (int addr = 0; addr < TBL_DEPTH; addr++) begin
      send_entry(ADDR_W'(addr), PAL_W'($urandom));
    end
  endtask

  task automatic test_random_mix(input int send_pct, input int recv_pct);
    logic [COUNT_W-1:0] counts [4];
    set_idle(send_pct, recv_pct);
    counts[0] = 7'd113;
    counts[1] = 7'($urandom_range(112, 1));
    counts[2] = 7'd0;
    counts[3] = 7'($urandom_range(127, 114));
    for (int seg = 0; seg < 4; seg++) begin
      set_intensity(counts[seg]);
      repeat (SEGMENT_WORDS) send_random_word(15);
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    cmd          = CMD_PIXEL;
    col_low      = '0;
    row_low      = '0;
    red_in       = '0;
    green_in     = '0;
    blue_in      = '0;
    entry_addr   = '0;
    entry_value  = '0;
    mismatches   = 0;
    count_shadow = '0;
    foreach (palette_shadow[i]) palette_shadow[i] = '0;
    set_idle(28, 53);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_saturation();
    test_thresholds();
    test_table_fill();
    test_random_mix(28, 53);
    test_random_mix(53, 28);
    test_random_mix(0, 0);
    drain_words();

    if (mismatches == 0 && palette_due.size() == 0) begin
      $display("** ordered_dither_palette_index: PASSED **");
    end else begin
      $display("** ordered_dither_palette_index: FAILED **");
    end
    $finish;
  end

endmodule

// ===== ordered_dither_palette_index.f =====
sv/odp_pkg.sv
sv/odp_table.sv
sv/ordered_dither_palette_index.sv
tb/sv/tb_ordered_dither_palette_index.sv
